// File: sv/quadratic_root_solver_assert.svh
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define QRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quadratic_root_solver: assertion failed");

// Next-cycle implication, checked outside reset.
`define QRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quadratic_root_solver: assertion failed");

`endif

// File: sv/qrs_pkg.sv
package qrs_pkg;

    localparam int CoefW     = 16;
    localparam int RootW     = 32;
    localparam int DiscW     = 34;
    localparam int NbW       = 25;
    localparam int SqrtW     = 25;
    localparam int RadW      = 2 * SqrtW;
    localparam int SremW     = SqrtW + 2;
    localparam int NumW      = 27;
    localparam int MagW      = 26;
    localparam int DvdW      = MagW + 7;
    localparam int DremW     = CoefW + 1;
    localparam int FifoDepth = 4;

    localparam logic [1:0] STAT_NONE  = 2'd0;
    localparam logic [1:0] STAT_ONE   = 2'd1;
    localparam logic [1:0] STAT_TWO   = 2'd2;
    localparam logic [1:0] STAT_AZERO = 2'd3;

    localparam logic signed [RootW-1:0] ROOT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [RootW-1:0] ROOT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [CoefW-1:0] coef_a;
        logic signed [CoefW-1:0] coef_b;
        logic signed [CoefW-1:0] coef_c;
    } qrs_in_t;

    typedef struct packed {
        logic [1:0]              root_status;
        logic signed [RootW-1:0] root_plus;
        logic signed [RootW-1:0] root_minus;
        logic                    root_saturated;
    } qrs_out_t;

    // Classified equation handed from front to back.
    typedef struct packed {
        logic [1:0]            status;
        logic                  a_neg;
        logic [CoefW-1:0]      den;
        logic signed [NbW-1:0] nb;
        logic [DiscW-2:0]      disc;
    } qrs_task_t;

endpackage

// File: sv/qrs_if.sv
interface qrs_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/qrs_fifo.sv
module qrs_fifo #(
    parameter int DEPTH = qrs_pkg::FifoDepth
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  qrs_pkg::qrs_task_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output qrs_pkg::qrs_task_t pop_data
);
    import qrs_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    qrs_task_t         mem_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]   count_reg;
    logic              push, pop;

    assign push_ready = (count_reg != CntW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

// File: sv/qrs_front.sv
module qrs_front (
    input  logic               clk,
    input  logic               rst_n,
    qrs_if.sink                coef_in,
    output logic               task_valid,
    input  logic               task_ready,
    output qrs_pkg::qrs_task_t task_data
);
    import qrs_pkg::*;

    logic                      v1_reg, v2_reg;
    logic signed [CoefW-1:0]   a1_reg, b1_reg;
    logic signed [2*CoefW-1:0] bb1_reg, ac1_reg;
    qrs_task_t                 t2_reg;
    qrs_task_t                 t2_next;
    logic signed [DiscW-1:0]   disc;
    logic                      adv1, adv2;

    assign adv2          = !v2_reg || task_ready;
    assign adv1          = !v1_reg || adv2;
    assign coef_in.ready = adv1;
    assign task_valid    = v2_reg;
    assign task_data     = t2_reg;

    always_comb
    begin
        disc = DiscW'(bb1_reg) - (DiscW'(ac1_reg) <<< 2);
        t2_next.disc  = disc[DiscW-2:0];
        t2_next.a_neg = a1_reg[CoefW-1];
        t2_next.den   = a1_reg[CoefW-1] ? CoefW'(-a1_reg) : CoefW'(a1_reg);
        t2_next.nb    = -(NbW'(b1_reg) <<< 8);
        priority if (a1_reg == '0)
        begin
            t2_next.status = STAT_AZERO;
        end
        else if (disc < 0)
        begin
            t2_next.status = STAT_NONE;
        end
        else if (disc == '0)
        begin
            t2_next.status = STAT_ONE;
        end
        else
        begin
            t2_next.status = STAT_TWO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            a1_reg  <= coef_in.data.coef_a;
            b1_reg  <= coef_in.data.coef_b;
            bb1_reg <= coef_in.data.coef_b * coef_in.data.coef_b;
            ac1_reg <= coef_in.data.coef_a * coef_in.data.coef_c;
        end
        if (adv2)
        begin
            t2_reg <= t2_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= coef_in.valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end
endmodule

// File: sv/qrs_back.sv
`include "quadratic_root_solver_assert.svh"

module qrs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               task_valid,
    output logic               task_ready,
    input  qrs_pkg::qrs_task_t task_data,
    qrs_if.source              root_out
);
    import qrs_pkg::*;

    localparam int SqN = SqrtW;
    localparam int DvN = DvdW;

    // Square-root phase: one result bit per stage.
    logic [SqN:0]          sq_v_reg;
    logic [1:0]            sq_stat_reg [SqN+1];
    logic                  sq_aneg_reg [SqN+1];
    logic [CoefW-1:0]      sq_den_reg  [SqN+1];
    logic signed [NbW-1:0] sq_nb_reg   [SqN+1];
    logic [RadW-1:0]       sq_rad_reg  [SqN+1];
    logic [SremW-1:0]      sq_rem_reg  [SqN+1];
    logic [SqrtW-1:0]      sq_root_reg [SqN+1];
    logic [RadW-1:0]       sq_rad_next [SqN];
    logic [SremW-1:0]      sq_rem_next [SqN];
    logic [SqrtW-1:0]      sq_root_next[SqN];

    // Division phase: one quotient bit per stage, both roots side by side.
    logic [DvN:0]          dv_v_reg;
    logic [1:0]            dv_stat_reg [DvN+1];
    logic [CoefW-1:0]      dv_den_reg  [DvN+1];
    logic                  dv_pneg_reg [DvN+1];
    logic                  dv_mneg_reg [DvN+1];
    logic [DvdW-1:0]       dv_pdvd_reg [DvN+1];
    logic [DremW-1:0]      dv_prem_reg [DvN+1];
    logic [DvdW-1:0]       dv_mdvd_reg [DvN+1];
    logic [DremW-1:0]      dv_mrem_reg [DvN+1];
    logic [DvdW-1:0]       dv_pdvd_next[DvN];
    logic [DremW-1:0]      dv_prem_next[DvN];
    logic [DvdW-1:0]       dv_mdvd_next[DvN];
    logic [DremW-1:0]      dv_mrem_next[DvN];

    logic signed [NumW-1:0] num_p, num_m;
    logic [NumW-1:0]        mag_p, mag_m;

    qrs_out_t out_reg, out_next;
    logic     out_v_reg;
    logic     en;
    logic [RootW:0] sat_p, sat_m;

    function automatic logic [RootW:0] saturate(logic [DvdW-1:0] mag, logic neg);
        logic [RootW:0] r;
        if (neg)
        begin
            if (mag > DvdW'(33'h0_8000_0000))
            begin
                r = {1'b1, ROOT_MIN};
            end
            else
            begin
                r = {1'b0, RootW'(-mag)};
            end
        end
        else
        begin
            if (mag > DvdW'(33'h0_7FFF_FFFF))
            begin
                r = {1'b1, ROOT_MAX};
            end
            else
            begin
                r = {1'b0, mag[RootW-1:0]};
            end
        end
        return r;
    endfunction

    assign en              = !out_v_reg || root_out.ready;
    assign task_ready      = en;
    assign root_out.valid  = out_v_reg;
    assign root_out.data   = out_reg;

    always_comb
    begin
        for (int k = 0; k < SqN; k++)
        begin
            logic [SremW+1:0] trial, test;
            logic             ge;
            trial = {sq_rem_reg[k], sq_rad_reg[k][RadW-1 -: 2]};
            test  = {2'b00, sq_root_reg[k], 2'b01};
            ge    = (trial >= test);
            sq_rem_next[k]  = ge ? SremW'(trial - test) : SremW'(trial);
            sq_root_next[k] = {sq_root_reg[k][SqrtW-2:0], ge};
            sq_rad_next[k]  = sq_rad_reg[k] << 2;
        end
    end

    always_comb
    begin
        num_p = NumW'(sq_nb_reg[SqN]) + $signed({2'b00, sq_root_reg[SqN]});
        num_m = NumW'(sq_nb_reg[SqN]) - $signed({2'b00, sq_root_reg[SqN]});
        mag_p = num_p[NumW-1] ? NumW'(-num_p) : NumW'(num_p);
        mag_m = num_m[NumW-1] ? NumW'(-num_m) : NumW'(num_m);
    end

    always_comb
    begin
        for (int j = 0; j < DvN; j++)
        begin
            logic [DremW-1:0] tp, tm, dd;
            logic             gp, gm;
            dd = {1'b0, dv_den_reg[j]};
            tp = {dv_prem_reg[j][DremW-2:0], dv_pdvd_reg[j][DvdW-1]};
            tm = {dv_mrem_reg[j][DremW-2:0], dv_mdvd_reg[j][DvdW-1]};
            gp = (tp >= dd);
            gm = (tm >= dd);
            dv_prem_next[j] = gp ? tp - dd : tp;
            dv_mrem_next[j] = gm ? tm - dd : tm;
            dv_pdvd_next[j] = {dv_pdvd_reg[j][DvdW-2:0], gp};
            dv_mdvd_next[j] = {dv_mdvd_reg[j][DvdW-2:0], gm};
        end
    end

    always_comb
    begin
        sat_p = saturate(dv_pdvd_reg[DvN], dv_pneg_reg[DvN]);
        sat_m = saturate(dv_mdvd_reg[DvN], dv_mneg_reg[DvN]);
        out_next.root_status = dv_stat_reg[DvN];
        if (dv_stat_reg[DvN] == STAT_ONE || dv_stat_reg[DvN] == STAT_TWO)
        begin
            out_next.root_plus      = sat_p[RootW-1:0];
            out_next.root_minus     = sat_m[RootW-1:0];
            out_next.root_saturated = sat_p[RootW] | sat_m[RootW];
        end
        else
        begin
            out_next.root_plus      = '0;
            out_next.root_minus     = '0;
            out_next.root_saturated = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_stat_reg[0] <= task_data.status;
            sq_aneg_reg[0] <= task_data.a_neg;
            sq_den_reg[0]  <= task_data.den;
            sq_nb_reg[0]   <= task_data.nb;
            sq_rad_reg[0]  <= {1'b0, task_data.disc, 16'h0000};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            for (int k = 0; k < SqN; k++)
            begin
                sq_stat_reg[k+1] <= sq_stat_reg[k];
                sq_aneg_reg[k+1] <= sq_aneg_reg[k];
                sq_den_reg[k+1]  <= sq_den_reg[k];
                sq_nb_reg[k+1]   <= sq_nb_reg[k];
                sq_rad_reg[k+1]  <= sq_rad_next[k];
                sq_rem_reg[k+1]  <= sq_rem_next[k];
                sq_root_reg[k+1] <= sq_root_next[k];
            end

            dv_stat_reg[0] <= sq_stat_reg[SqN];
            dv_den_reg[0]  <= sq_den_reg[SqN];
            dv_pneg_reg[0] <= num_p[NumW-1] ^ sq_aneg_reg[SqN];
            dv_mneg_reg[0] <= num_m[NumW-1] ^ sq_aneg_reg[SqN];
            dv_pdvd_reg[0] <= {mag_p[MagW-1:0], 7'b0};
            dv_mdvd_reg[0] <= {mag_m[MagW-1:0], 7'b0};
            dv_prem_reg[0] <= '0;
            dv_mrem_reg[0] <= '0;
            for (int j = 0; j < DvN; j++)
            begin
                dv_stat_reg[j+1] <= dv_stat_reg[j];
                dv_den_reg[j+1]  <= dv_den_reg[j];
                dv_pneg_reg[j+1] <= dv_pneg_reg[j];
                dv_mneg_reg[j+1] <= dv_mneg_reg[j];
                dv_pdvd_reg[j+1] <= dv_pdvd_next[j];
                dv_mdvd_reg[j+1] <= dv_mdvd_next[j];
                dv_prem_reg[j+1] <= dv_prem_next[j];
                dv_mrem_reg[j+1] <= dv_mrem_next[j];
            end

            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg  <= '0;
            dv_v_reg  <= '0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg  <= {sq_v_reg[SqN-1:0], task_valid};
            dv_v_reg  <= {dv_v_reg[DvN-1:0], sq_v_reg[SqN]};
            out_v_reg <= dv_v_reg[DvN];
        end
    end

    `QRS_ASSERT_NOW(a_no_root_zero,
        out_v_reg && (out_reg.root_status == STAT_NONE || out_reg.root_status == STAT_AZERO),
        out_reg.root_plus == '0 && out_reg.root_minus == '0 && !out_reg.root_saturated)
    `QRS_ASSERT_NOW(a_one_root_equal,
        out_v_reg && out_reg.root_status == STAT_ONE,
        out_reg.root_plus == out_reg.root_minus)
    `QRS_ASSERT_NOW(a_sat_clipped,
        out_v_reg && out_reg.root_saturated,
        out_reg.root_plus == ROOT_MAX || out_reg.root_plus == ROOT_MIN
        || out_reg.root_minus == ROOT_MAX || out_reg.root_minus == ROOT_MIN)
    `QRS_ASSERT_NEXT(a_stall_holds_pipe,
        out_v_reg && !root_out.ready,
        $stable(dv_v_reg) && $stable(sq_v_reg))
endmodule

// File: sv/quadratic_root_solver.sv
// Throughput: one item per cycle while root_out is not stalled; the square-root
// stages (25, one bit each) and the two divider chains (33 stages, one quotient
// bit each) are fully pipelined.
// A 4-entry queue sits between the classifying front end and the solving back end.
// Reset (rst_n low, asynchronous) clears all valid bits and queue pointers; no item
// is in flight afterwards and coef_in.ready is high once the valid bits are clear.
module quadratic_root_solver #(
    parameter int FIFO_DEPTH = qrs_pkg::FifoDepth
) (
    input  logic clk,
    input  logic rst_n,
    qrs_if.sink   coef_in,
    qrs_if.source root_out
);
    import qrs_pkg::*;

    logic      f_valid, f_ready, b_valid, b_ready;
    qrs_task_t f_data, b_data;

    qrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_in    (coef_in),
        .task_valid (f_valid),
        .task_ready (f_ready),
        .task_data  (f_data)
    );

    qrs_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    qrs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_valid (b_valid),
        .task_ready (b_ready),
        .task_data  (b_data),
        .root_out   (root_out)
    );
endmodule
